[hdl/bui_pkg.sv]
// ----------------------------------------------------------------------------
// bui_pkg
// shared widths, register indexes and word types of the uv interpolator
// ----------------------------------------------------------------------------
package bui_pkg;

    // fixed field formats
    localparam int COORD_WIDTH = 20;   // signed q12.8 coordinates
    localparam int UV_WIDTH    = 16;   // signed q4.12 corner uv
    localparam int UV_FRAC     = 12;
    localparam int OUT_FRAC    = 16;
    localparam int TEX_WIDTH   = 16;   // unsigned q0.16 result

    // dot products and determinant terms
    localparam int D_WIDTH     = 2 * COORD_WIDTH + 3;
    localparam int N_WIDTH     = 2 * D_WIDTH + 1;

    // operand slice of the split multipliers
    localparam int MUL_CHUNK   = 22;

    // configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 3 * COORD_WIDTH;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_VERTEX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_AB     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_AC     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UV_FIRST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UV_SECOND   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UV_THIRD    = 3'd5;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_z;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_x;
    } point_t;

    typedef struct packed {
        logic                   degenerate;
        logic [TEX_WIDTH-1:0]   tex_v;
        logic [TEX_WIDTH-1:0]   tex_u;
    } result_t;

    // word handed from the front to the back
    typedef struct packed {
        logic                      degenerate;
        logic signed [N_WIDTH-1:0] den;
        logic signed [N_WIDTH-1:0] n2;
        logic signed [N_WIDTH-1:0] n3;
    } mid_t;

endpackage

[hdl/bui_mul.sv]
// ----------------------------------------------------------------------------
// bui_mul
// two-stage signed multiplier built from narrow partial products
// ----------------------------------------------------------------------------
module bui_mul #(
    parameter int A_W = 43,
    parameter int B_W = 43,
    parameter int CH  = 22
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [A_W-1:0]    a,
    input  logic signed [B_W-1:0]    b,
    output logic signed [A_W+B_W-1:0] p
);

    localparam int NA   = (A_W + CH - 1) / CH;
    localparam int NB   = (B_W + CH - 1) / CH;
    localparam int AX_W = NA * CH + 1;
    localparam int BX_W = NB * CH + 1;
    localparam int PP_W = 2 * CH + 2;
    localparam int S_W  = (NA + NB) * CH + 4;
    localparam int P_W  = A_W + B_W;

    logic [AX_W-1:0] ax;
    logic [BX_W-1:0] bx;

    logic signed [PP_W-1:0] pp_next [NA*NB];
    logic signed [PP_W-1:0] pp_reg  [NA*NB];
    logic signed [S_W-1:0]  sum_next;
    logic signed [S_W-1:0]  sum_reg;

    assign ax = {{(AX_W-A_W){a[A_W-1]}}, a};
    assign bx = {{(BX_W-B_W){b[B_W-1]}}, b};

    // low slices are unsigned, the top slice carries the sign
    always_comb
    begin
        logic signed [CH:0] oa;
        logic signed [CH:0] ob;
        for (int i = 0; i < NA; i++)
        begin
            oa = {((i == NA - 1) ? ax[i*CH+CH-1] : 1'b0), ax[i*CH +: CH]};
            for (int j = 0; j < NB; j++)
            begin
                ob = {((j == NB - 1) ? bx[j*CH+CH-1] : 1'b0), bx[j*CH +: CH]};
                pp_next[i*NB+j] = oa * ob;
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                sum_next = sum_next + (S_W'(pp_reg[i*NB+j]) <<< ((i + j) * CH));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg  <= pp_next;
            sum_reg <= sum_next;
        end
    end

    assign p = sum_reg[P_W-1:0];

endmodule

[hdl/bui_div.sv]
// ----------------------------------------------------------------------------
// bui_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module bui_div #(
    parameter int NUM_W = 110,
    parameter int DEN_W = 86,
    parameter int Q_W   = 16,
    parameter int TAG_W = 2
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag,
    output logic [Q_W-1:0]   quot,
    output logic [DEN_W-1:0] rem,
    output logic [TAG_W-1:0] tag_out
);

    logic [DEN_W-1:0] r_next [NUM_W];
    logic [DEN_W-1:0] r_reg  [NUM_W];
    logic [NUM_W-1:0] n_next [NUM_W];
    logic [NUM_W-1:0] n_reg  [NUM_W];
    logic [DEN_W-1:0] d_next [NUM_W];
    logic [DEN_W-1:0] d_reg  [NUM_W];
    logic [Q_W-1:0]   q_next [NUM_W];
    logic [Q_W-1:0]   q_reg  [NUM_W];
    logic [TAG_W-1:0] t_next [NUM_W];
    logic [TAG_W-1:0] t_reg  [NUM_W];

    always_comb
    begin
        logic [DEN_W-1:0] r_prev;
        logic [NUM_W-1:0] n_prev;
        logic [DEN_W-1:0] d_prev;
        logic [Q_W-1:0]   q_prev;
        logic [TAG_W-1:0] t_prev;
        logic [DEN_W:0]   rs;
        logic             ge;
        for (int k = 0; k < NUM_W; k++)
        begin
            if (k == 0)
            begin
                r_prev = '0;
                n_prev = num;
                d_prev = den;
                q_prev = '0;
                t_prev = tag;
            end
            else
            begin
                r_prev = r_reg[k-1];
                n_prev = n_reg[k-1];
                d_prev = d_reg[k-1];
                q_prev = q_reg[k-1];
                t_prev = t_reg[k-1];
            end
            rs = {r_prev, n_prev[NUM_W-1]};
            ge = rs >= {1'b0, d_prev};
            r_next[k] = ge ? DEN_W'(rs - {1'b0, d_prev}) : rs[DEN_W-1:0];
            n_next[k] = {n_prev[NUM_W-2:0], 1'b0};
            d_next[k] = d_prev;
            q_next[k] = {q_prev[Q_W-2:0], ge};
            t_next[k] = t_prev;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
            n_reg <= n_next;
            d_reg <= d_next;
            q_reg <= q_next;
            t_reg <= t_next;
        end
    end

    assign quot    = q_reg[NUM_W-1];
    assign rem     = r_reg[NUM_W-1];
    assign tag_out = t_reg[NUM_W-1];

endmodule

[hdl/bui_fifo.sv]
// ----------------------------------------------------------------------------
// bui_fifo
// small register queue with count-based full and empty
// ----------------------------------------------------------------------------
module bui_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         full,
    output logic         empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;

endmodule

[hdl/bui_front.sv]
// ----------------------------------------------------------------------------
// bui_front
// dot products, gram determinant, weight numerators and degenerate flag
// ----------------------------------------------------------------------------
module bui_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  bui_pkg::point_t                     point,
    input  logic [bui_pkg::CFG_DATA_W-1:0]      base_vertex,
    input  logic [bui_pkg::CFG_DATA_W-1:0]      edge_ab,
    input  logic [bui_pkg::CFG_DATA_W-1:0]      edge_ac,
    input  logic                                mid_full,
    output logic                                mid_push,
    output bui_pkg::mid_t                       mid_word
);

    localparam int CW  = bui_pkg::COORD_WIDTH;
    localparam int D_W = bui_pkg::D_WIDTH;
    localparam int N_W = bui_pkg::N_WIDTH;
    localparam int LAT = 7;

    logic [LAT-1:0] v_reg, v_next;
    logic           en;
    logic           accept;

    logic signed [CW-1:0]     p_reg   [3];
    logic signed [CW:0]       dp_next [3];
    logic signed [CW:0]       dp_reg  [3];
    logic signed [CW-1:0]     e1      [3];
    logic signed [CW-1:0]     e2      [3];
    logic signed [CW-1:0]     va      [3];

    logic signed [2*CW-1:0]   p00_reg [3];
    logic signed [2*CW-1:0]   p01_reg [3];
    logic signed [2*CW-1:0]   p11_reg [3];
    logic signed [2*CW:0]     p20_reg [3];
    logic signed [2*CW:0]     p21_reg [3];

    logic signed [D_W-1:0]    d00_reg, d01_reg, d11_reg, d20_reg, d21_reg;
    logic signed [D_W-1:0]    ma [6];
    logic signed [D_W-1:0]    mb [6];
    logic signed [2*D_W-1:0]  mp [6];

    logic signed [N_W-1:0]    den_reg, n2_reg, n3_reg;
    logic                     degen_reg;

    assign en     = !(v_reg[LAT-1] && mid_full);
    assign full   = !en;
    assign accept = push && en;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = edge_ab[i*CW +: CW];
            e2[i] = edge_ac[i*CW +: CW];
            va[i] = base_vertex[i*CW +: CW];
            dp_next[i] = (CW+1)'(p_reg[i]) - (CW+1)'(va[i]);
        end
        v_next = {v_reg[LAT-2:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= point.point_x;
            p_reg[1] <= point.point_y;
            p_reg[2] <= point.point_z;
            dp_reg   <= dp_next;
            for (int i = 0; i < 3; i++)
            begin
                p00_reg[i] <= e1[i] * e1[i];
                p01_reg[i] <= e1[i] * e2[i];
                p11_reg[i] <= e2[i] * e2[i];
                p20_reg[i] <= dp_reg[i] * e1[i];
                p21_reg[i] <= dp_reg[i] * e2[i];
            end
            d00_reg <= D_W'(p00_reg[0]) + D_W'(p00_reg[1]) + D_W'(p00_reg[2]);
            d01_reg <= D_W'(p01_reg[0]) + D_W'(p01_reg[1]) + D_W'(p01_reg[2]);
            d11_reg <= D_W'(p11_reg[0]) + D_W'(p11_reg[1]) + D_W'(p11_reg[2]);
            d20_reg <= D_W'(p20_reg[0]) + D_W'(p20_reg[1]) + D_W'(p20_reg[2]);
            d21_reg <= D_W'(p21_reg[0]) + D_W'(p21_reg[1]) + D_W'(p21_reg[2]);
            den_reg   <= N_W'(mp[0]) - N_W'(mp[1]);
            n2_reg    <= N_W'(mp[2]) - N_W'(mp[3]);
            n3_reg    <= N_W'(mp[4]) - N_W'(mp[5]);
            degen_reg <= mp[0] == mp[1];
        end
    end

    // den = d00*d11 - d01*d01, n2 = d11*d20 - d01*d21, n3 = d00*d21 - d01*d20
    assign ma[0] = d00_reg;  assign mb[0] = d11_reg;
    assign ma[1] = d01_reg;  assign mb[1] = d01_reg;
    assign ma[2] = d11_reg;  assign mb[2] = d20_reg;
    assign ma[3] = d01_reg;  assign mb[3] = d21_reg;
    assign ma[4] = d00_reg;  assign mb[4] = d21_reg;
    assign ma[5] = d01_reg;  assign mb[5] = d20_reg;

    for (genvar m = 0; m < 6; m++)
    begin : g_mul
        bui_mul #(
            .A_W (D_W),
            .B_W (D_W),
            .CH  (bui_pkg::MUL_CHUNK)
        ) u_mul (
            .clk (clk),
            .en  (en),
            .a   (ma[m]),
            .b   (mb[m]),
            .p   (mp[m])
        );
    end

    assign mid_push            = v_reg[LAT-1] && !mid_full;
    assign mid_word.degenerate = degen_reg;
    assign mid_word.den        = den_reg;
    assign mid_word.n2         = n2_reg;
    assign mid_word.n3         = n3_reg;

endmodule

[hdl/bui_back.sv]
// ----------------------------------------------------------------------------
// bui_back
// uv interpolation over the determinant and floor division per channel
// ----------------------------------------------------------------------------
module bui_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 mid_empty,
    output logic                                 mid_pop,
    input  bui_pkg::mid_t                        mid_word,
    input  logic [2*bui_pkg::UV_WIDTH-1:0]       uv_first,
    input  logic [2*bui_pkg::UV_WIDTH-1:0]       uv_second,
    input  logic [2*bui_pkg::UV_WIDTH-1:0]       uv_third,
    input  logic                                 out_full,
    output logic                                 out_push,
    output bui_pkg::result_t                     out_word
);

    localparam int UV_W  = bui_pkg::UV_WIDTH;
    localparam int N_W   = bui_pkg::N_WIDTH;
    localparam int TEX_W = bui_pkg::TEX_WIDTH;
    localparam int ACC_W = UV_W + N_W + 3;
    localparam int SHIFT = bui_pkg::OUT_FRAC - bui_pkg::UV_FRAC;
    localparam int NUM_W = ACC_W + SHIFT;
    localparam int DEN_W = N_W - 1;
    localparam int LAT   = NUM_W + 6;

    logic [LAT-1:0] v_reg, v_next;
    logic           en;

    logic signed [N_W-1:0]  den0_reg, n2_0_reg, n3_0_reg, den1_reg, den2_reg, den3_reg;
    logic                   degen0_reg, degen1_reg, degen2_reg, degen3_reg, degen4_reg;
    logic signed [UV_W-1:0] a_next  [2];
    logic signed [UV_W:0]   db_next [2];
    logic signed [UV_W:0]   dt_next [2];
    logic signed [UV_W-1:0] a0_reg  [2];
    logic signed [UV_W:0]   db0_reg [2];
    logic signed [UV_W:0]   dt0_reg [2];

    logic signed [UV_W+N_W-1:0] pa [2];
    logic signed [UV_W+N_W:0]   pb [2];
    logic signed [UV_W+N_W:0]   pc [2];
    logic signed [ACC_W-1:0]    acc_reg [2];

    logic [NUM_W-1:0] num    [2];
    logic [NUM_W-1:0] mag4_reg [2];
    logic             neg4_reg [2];
    logic [DEN_W-1:0] den4_reg;

    logic [TEX_W-1:0] quot    [2];
    logic [DEN_W-1:0] rem     [2];
    logic [1:0]       tag_out [2];
    logic [TEX_W-1:0] tex_next [2];
    logic [TEX_W-1:0] tex_reg  [2];
    logic             degen_next, degen5_reg;

    assign en      = !(v_reg[LAT-1] && out_full);
    assign mid_pop = en && !mid_empty;

    always_comb
    begin
        logic signed [UV_W-1:0] b_c;
        logic signed [UV_W-1:0] t_c;
        for (int c = 0; c < 2; c++)
        begin
            a_next[c]  = uv_first[c*UV_W +: UV_W];
            b_c        = uv_second[c*UV_W +: UV_W];
            t_c        = uv_third[c*UV_W +: UV_W];
            db_next[c] = (UV_W+1)'(b_c) - (UV_W+1)'(a_next[c]);
            dt_next[c] = (UV_W+1)'(t_c) - (UV_W+1)'(a_next[c]);
            num[c]     = {acc_reg[c], {SHIFT{1'b0}}};
        end
        v_next = {v_reg[LAT-2:0], mid_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den0_reg   <= mid_word.den;
            n2_0_reg   <= mid_word.n2;
            n3_0_reg   <= mid_word.n3;
            degen0_reg <= mid_word.degenerate;
            a0_reg     <= a_next;
            db0_reg    <= db_next;
            dt0_reg    <= dt_next;
            den1_reg   <= den0_reg;
            den2_reg   <= den1_reg;
            den3_reg   <= den2_reg;
            degen1_reg <= degen0_reg;
            degen2_reg <= degen1_reg;
            degen3_reg <= degen2_reg;
            degen4_reg <= degen3_reg;
            den4_reg   <= den3_reg[DEN_W-1:0];
            for (int c = 0; c < 2; c++)
            begin
                acc_reg[c]  <= ACC_W'(pa[c]) + ACC_W'(pb[c]) + ACC_W'(pc[c]);
                neg4_reg[c] <= acc_reg[c][ACC_W-1];
                mag4_reg[c] <= acc_reg[c][ACC_W-1] ? (~num[c] + 1'b1) : num[c];
            end
            tex_reg    <= tex_next;
            degen5_reg <= degen_next;
        end
    end

    for (genvar c = 0; c < 2; c++)
    begin : g_chan
        // uv*den = a*den + (b-a)*n2 + (t-a)*n3
        bui_mul #(
            .A_W (UV_W),
            .B_W (N_W),
            .CH  (bui_pkg::MUL_CHUNK)
        ) u_mul_a (
            .clk (clk),
            .en  (en),
            .a   (a0_reg[c]),
            .b   (den0_reg),
            .p   (pa[c])
        );

        bui_mul #(
            .A_W (UV_W + 1),
            .B_W (N_W),
            .CH  (bui_pkg::MUL_CHUNK)
        ) u_mul_b (
            .clk (clk),
            .en  (en),
            .a   (db0_reg[c]),
            .b   (n2_0_reg),
            .p   (pb[c])
        );

        bui_mul #(
            .A_W (UV_W + 1),
            .B_W (N_W),
            .CH  (bui_pkg::MUL_CHUNK)
        ) u_mul_t (
            .clk (clk),
            .en  (en),
            .a   (dt0_reg[c]),
            .b   (n3_0_reg),
            .p   (pc[c])
        );

        bui_div #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W),
            .Q_W   (TEX_W),
            .TAG_W (2)
        ) u_div (
            .clk     (clk),
            .en      (en),
            .num     (mag4_reg[c]),
            .den     (den4_reg),
            .tag     ({degen4_reg, neg4_reg[c]}),
            .quot    (quot[c]),
            .rem     (rem[c]),
            .tag_out (tag_out[c])
        );
    end

    // floor of a negative quotient: negate and step down on a remainder
    always_comb
    begin
        degen_next = tag_out[0][1] | tag_out[1][1];
        for (int c = 0; c < 2; c++)
        begin
            if (degen_next)
            begin
                tex_next[c] = '0;
            end
            else if (tag_out[c][0])
            begin
                tex_next[c] = TEX_W'(0) - quot[c] - TEX_W'(|rem[c]);
            end
            else
            begin
                tex_next[c] = quot[c];
            end
        end
    end

    assign out_push            = v_reg[LAT-1] && !out_full;
    assign out_word.tex_u      = tex_reg[0];
    assign out_word.tex_v      = tex_reg[1];
    assign out_word.degenerate = degen5_reg;

endmodule

[hdl/barycentric_uv_interpolator_top.sv]
// ----------------------------------------------------------------------------
// barycentric_uv_interpolator_top
// texture coordinates of a hit point from the barycentric weights of one
// configured triangle
// ----------------------------------------------------------------------------
// one point word enters per clock while full is low, and one result word
// leaves per clock for each point, in order, while pop is held and a result
// waits. a result passes the front (offset, dot products, determinant), then
// the short queue, then the back, most of which is the pipelined restoring
// divider that takes one quotient bit per stage over the full numerator
// width. full rises only while the front holds a finished word that the
// middle queue cannot take, and the back stalls only while its last stage
// holds a word and the result queue is full.
// configuration writes are always ready and take effect in the next cycle; write
// them only while no point is in flight.
module barycentric_uv_interpolator_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // point words
    input  logic                               push,
    output logic                               full,
    input  bui_pkg::point_t                    point,
    // result words
    output logic                               empty,
    input  logic                               pop,
    output bui_pkg::result_t                   result,
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bui_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bui_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int UVP_W     = 2 * bui_pkg::UV_WIDTH;
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    // triangle registers
    logic [bui_pkg::CFG_DATA_W-1:0] base_vertex_reg;
    logic [bui_pkg::CFG_DATA_W-1:0] edge_ab_reg;
    logic [bui_pkg::CFG_DATA_W-1:0] edge_ac_reg;
    logic [UVP_W-1:0]               uv_first_reg;
    logic [UVP_W-1:0]               uv_second_reg;
    logic [UVP_W-1:0]               uv_third_reg;

    // front to back queue
    logic             mid_push;
    logic             mid_pop;
    logic             mid_full;
    logic             mid_empty;
    bui_pkg::mid_t    mid_in;
    bui_pkg::mid_t    mid_out;

    // back to result queue
    logic             out_push;
    logic             out_full;
    bui_pkg::result_t out_word;

    // the register port never back-pressures
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_vertex_reg <= '0;
            edge_ab_reg     <= '0;
            edge_ac_reg     <= '0;
            uv_first_reg    <= '0;
            uv_second_reg   <= '0;
            uv_third_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bui_pkg::REG_BASE_VERTEX: base_vertex_reg <= cfg_data;
                bui_pkg::REG_EDGE_AB:     edge_ab_reg     <= cfg_data;
                bui_pkg::REG_EDGE_AC:     edge_ac_reg     <= cfg_data;
                bui_pkg::REG_UV_FIRST:    uv_first_reg    <= cfg_data[UVP_W-1:0];
                bui_pkg::REG_UV_SECOND:   uv_second_reg   <= cfg_data[UVP_W-1:0];
                bui_pkg::REG_UV_THIRD:    uv_third_reg    <= cfg_data[UVP_W-1:0];
                default:
                begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // front: p - a, the five dot products, determinant and numerators
    bui_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .point       (point),
        .base_vertex (base_vertex_reg),
        .edge_ab     (edge_ab_reg),
        .edge_ac     (edge_ac_reg),
        .mid_full    (mid_full),
        .mid_push    (mid_push),
        .mid_word    (mid_in)
    );

    // short queue so the front and back stall independently
    bui_fifo #(
        .W     ($bits(bui_pkg::mid_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_data (mid_in),
        .rd_en   (mid_pop),
        .rd_data (mid_out),
        .full    (mid_full),
        .empty   (mid_empty)
    );

    // back: interpolated numerators, floor divide by the determinant, wrap
    bui_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .mid_word  (mid_out),
        .uv_first  (uv_first_reg),
        .uv_second (uv_second_reg),
        .uv_third  (uv_third_reg),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_word  (out_word)
    );

    // result queue, the oldest word sits on the result port
    bui_fifo #(
        .W     ($bits(bui_pkg::result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_word),
        .rd_en   (pop && !empty),
        .rd_data (result),
        .full    (out_full),
        .empty   (empty)
    );

    // the input only holds off while the middle queue is full
    a_full_needs_mid_full : assert property (
        @(posedge clk) disable iff (!rst_n)
        full |-> mid_full
    ) else $error("full raised while the middle queue has room");

    // a degenerate triangle gives zero coordinates
    a_degenerate_zero : assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && result.degenerate) |-> (result.tex_u == '0 && result.tex_v == '0)
    ) else $error("degenerate word with nonzero coordinates");

    // a word taken from the middle queue never comes from an empty queue
    a_mid_pop_nonempty : assert property (
        @(posedge clk) disable iff (!rst_n)
        mid_pop |-> !mid_empty
    ) else $error("middle queue read while empty");

endmodule
